// File: rtl/view_box_extent_projector_assert.svh
// Assertion macros used by the top level of the view box extent projector RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef VIEW_BOX_EXTENT_PROJECTOR_ASSERT_SVH
`define VIEW_BOX_EXTENT_PROJECTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define VBEP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define VBEP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define VBEP_ASSERT(lbl, prop, msg)

`define VBEP_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/vbep_pkg.sv
// Shared widths, constants and payload types for the view box extent projector.
// No dependencies; used by every module of the block by scoped names.
package vbep_pkg;

	localparam int NUM_LANES  = 8;
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int DIR_W      = 16;
	localparam int XA_W       = 18;
	localparam int FRAC_SHIFT = 14;
	localparam int X_PROD_W   = DIFF_W + XA_W;
	localparam int D_PROD_W   = DIFF_W + DIR_W;
	localparam int DOT_W      = X_PROD_W + 2;
	localparam int CFG_W      = 3 * DIR_W;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_UP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_X  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_Z  = 3'd4;

	localparam logic [CFG_W-1:0] UP_RESET     = 48'h0000_0000_4000;
	localparam logic [CFG_W-1:0] NORMAL_RESET = 48'h0000_4000_0000;

	localparam logic signed [DOT_W-1:0] ROUND_HALF = DOT_W'(8192);
	localparam logic signed [DOT_W-1:0] SAT_MAX    = DOT_W'(64'sd2147483647);
	localparam logic signed [DOT_W-1:0] SAT_MIN    = -SAT_MAX - DOT_W'(1);

	typedef logic signed [DIFF_W-1:0] diff_t;

	// member order puts x in the low bits, matching the register packing
	typedef struct packed {
		logic signed [DIR_W-1:0] z;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] x;
	} dir_t;

	typedef struct packed {
		logic signed [XA_W-1:0] z;
		logic signed [XA_W-1:0] y;
		logic signed [XA_W-1:0] x;
	} xaxis_t;

	typedef struct packed {
		diff_t z;
		diff_t y;
		diff_t x;
	} corner_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} proj_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	localparam xaxis_t XA_RESET = '{z: 18'sd16384, y: 18'sd0, x: 18'sd0};

endpackage

// File: rtl/vbep_lane.sv
// One corner lane: three dot products of a reference-relative corner, then
// rounding to Q16.16 and saturation. Depends on vbep_pkg.
module vbep_lane (
	input  logic                clk,
	input  vbep_pkg::stage_en_t en,
	input  vbep_pkg::corner_t   d,
	input  vbep_pkg::xaxis_t    xa,
	input  vbep_pkg::dir_t      up,
	input  vbep_pkg::dir_t      nm,
	output vbep_pkg::proj_t     p
);

	localparam int XPW = vbep_pkg::X_PROD_W;
	localparam int DPW = vbep_pkg::D_PROD_W;
	localparam int SW  = vbep_pkg::DOT_W;

	logic signed [XPW-1:0] xp_s2 [3];
	logic signed [DPW-1:0] yp_s2 [3];
	logic signed [DPW-1:0] zp_s2 [3];
	logic signed [SW-1:0]  x_sum, y_sum, z_sum;
	vbep_pkg::proj_t       p_s3;

	function automatic logic signed [vbep_pkg::COORD_W-1:0] round_sat(
		input logic signed [SW-1:0] v
	);
		logic signed [SW-1:0] r;
		r = (v + vbep_pkg::ROUND_HALF) >>> vbep_pkg::FRAC_SHIFT;
		if (r > vbep_pkg::SAT_MAX) begin
			r = vbep_pkg::SAT_MAX;
		end else if (r < vbep_pkg::SAT_MIN) begin
			r = vbep_pkg::SAT_MIN;
		end
		return r[vbep_pkg::COORD_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en.s2) begin
			xp_s2[0] <= XPW'(d.x) * XPW'(xa.x);
			xp_s2[1] <= XPW'(d.y) * XPW'(xa.y);
			xp_s2[2] <= XPW'(d.z) * XPW'(xa.z);
			yp_s2[0] <= DPW'(d.x) * DPW'(up.x);
			yp_s2[1] <= DPW'(d.y) * DPW'(up.y);
			yp_s2[2] <= DPW'(d.z) * DPW'(up.z);
			zp_s2[0] <= DPW'(d.x) * DPW'(nm.x);
			zp_s2[1] <= DPW'(d.y) * DPW'(nm.y);
			zp_s2[2] <= DPW'(d.z) * DPW'(nm.z);
		end
	end

	always_comb begin
		x_sum = SW'(xp_s2[0]) + SW'(xp_s2[1]) + SW'(xp_s2[2]);
		y_sum = SW'(yp_s2[0]) + SW'(yp_s2[1]) + SW'(yp_s2[2]);
		z_sum = SW'(zp_s2[0]) + SW'(zp_s2[1]) + SW'(zp_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			p_s3.x <= round_sat(x_sum);
			p_s3.y <= round_sat(y_sum);
			p_s3.z <= round_sat(z_sum);
		end
	end

	assign p = p_s3;

endmodule

// File: rtl/vbep_merge.sv
// Merge stage: component-wise least and greatest of the lane results, as a
// two-stage registered tree. Depends on vbep_pkg.
module vbep_merge (
	input  logic                clk,
	input  vbep_pkg::stage_en_t en,
	input  vbep_pkg::proj_t     p [vbep_pkg::NUM_LANES],
	output vbep_pkg::proj_t     lo,
	output vbep_pkg::proj_t     hi
);

	localparam int NUM_GRP = 2;
	localparam int GRP_SZ  = vbep_pkg::NUM_LANES / NUM_GRP;

	vbep_pkg::proj_t lo_grp [NUM_GRP];
	vbep_pkg::proj_t hi_grp [NUM_GRP];
	vbep_pkg::proj_t lo_s4 [NUM_GRP];
	vbep_pkg::proj_t hi_s4 [NUM_GRP];
	vbep_pkg::proj_t lo_s5, hi_s5;

	function automatic vbep_pkg::proj_t pmin(input vbep_pkg::proj_t a, input vbep_pkg::proj_t b);
		vbep_pkg::proj_t r;
		r.x = (b.x < a.x) ? b.x : a.x;
		r.y = (b.y < a.y) ? b.y : a.y;
		r.z = (b.z < a.z) ? b.z : a.z;
		return r;
	endfunction

	function automatic vbep_pkg::proj_t pmax(input vbep_pkg::proj_t a, input vbep_pkg::proj_t b);
		vbep_pkg::proj_t r;
		r.x = (b.x > a.x) ? b.x : a.x;
		r.y = (b.y > a.y) ? b.y : a.y;
		r.z = (b.z > a.z) ? b.z : a.z;
		return r;
	endfunction

	// reduce each group of lanes to one partial extent
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			lo_grp[g] = p[g*GRP_SZ];
			hi_grp[g] = p[g*GRP_SZ];
			for (int j = 1; j < GRP_SZ; j++) begin
				lo_grp[g] = pmin(lo_grp[g], p[g*GRP_SZ + j]);
				hi_grp[g] = pmax(hi_grp[g], p[g*GRP_SZ + j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			lo_s4 <= lo_grp;
			hi_s4 <= hi_grp;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			lo_s5 <= pmin(lo_s4[0], lo_s4[1]);
			hi_s5 <= pmax(hi_s4[0], hi_s4[1]);
		end
	end

	assign lo = lo_s5;
	assign hi = hi_s5;

endmodule

// File: rtl/view_box_extent_projector.sv
// Top level of the view box extent projector: configuration registers,
// corner differencing, pipeline control. Uses vbep_pkg, vbep_lane, vbep_merge.
//
// Takes one box per clock cycle while out_ready does not hold the pipeline, through
// five register stages. Stage 1 subtracts the reference point from both corners.
// Stages 2 and 3 run eight corner lanes (nine multipliers each, then the Q16.16
// rounding and saturation). Stages 4 and 5 merge the lanes into least and
// greatest x, y and z. Every stage has its own valid bit, so bubbles are squeezed
// out. A new box is taken while a finished result waits at the output, as long as
// some stage is empty. The x axis (up cross normal) is held in a register that
// follows the up and normal registers, updating in the cycle after a write.
`include "view_box_extent_projector_assert.svh"

module view_box_extent_projector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vbep_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vbep_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [vbep_pkg::COORD_W-1:0] lower_x,
	input  logic signed [vbep_pkg::COORD_W-1:0] lower_y,
	input  logic signed [vbep_pkg::COORD_W-1:0] lower_z,
	input  logic signed [vbep_pkg::COORD_W-1:0] upper_x,
	input  logic signed [vbep_pkg::COORD_W-1:0] upper_y,
	input  logic signed [vbep_pkg::COORD_W-1:0] upper_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vbep_pkg::COORD_W-1:0] view_min_x,
	output logic signed [vbep_pkg::COORD_W-1:0] view_min_y,
	output logic signed [vbep_pkg::COORD_W-1:0] view_near_z,
	output logic signed [vbep_pkg::COORD_W-1:0] view_max_x,
	output logic signed [vbep_pkg::COORD_W-1:0] view_max_y,
	output logic signed [vbep_pkg::COORD_W-1:0] view_far_z
);

	localparam int DW  = vbep_pkg::DIFF_W;
	localparam int CW  = vbep_pkg::COORD_W;
	localparam int CPW = 2 * vbep_pkg::DIR_W + 1;
	localparam int XW  = vbep_pkg::XA_W;

	logic [vbep_pkg::CFG_W-1:0] up_q, nm_q;
	logic signed [CW-1:0]       ref_x_q, ref_y_q, ref_z_q;
	vbep_pkg::dir_t             up, nm;
	vbep_pkg::xaxis_t           xa_q;

	logic                       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                       load1, load2, load3, load4, load5;
	logic                       in_xfer, out_xfer, extent_ok;
	logic [2:0]                 v_cnt, v_cnt_next;
	vbep_pkg::stage_en_t        en;

	vbep_pkg::corner_t          d_lo_s1, d_hi_s1;
	vbep_pkg::corner_t          corner [vbep_pkg::NUM_LANES];
	vbep_pkg::proj_t            lane_p [vbep_pkg::NUM_LANES];
	vbep_pkg::proj_t            lo, hi;

	// round half up of a Q3.28 cross term to Q3.14
	function automatic logic signed [XW-1:0] cross_term(
		input logic signed [vbep_pkg::DIR_W-1:0] a,
		input logic signed [vbep_pkg::DIR_W-1:0] b,
		input logic signed [vbep_pkg::DIR_W-1:0] c,
		input logic signed [vbep_pkg::DIR_W-1:0] e
	);
		logic signed [CPW-1:0] t;
		t = CPW'(a) * CPW'(b) - CPW'(c) * CPW'(e) + CPW'(vbep_pkg::ROUND_HALF);
		return XW'(t >>> vbep_pkg::FRAC_SHIFT);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= vbep_pkg::UP_RESET;
			nm_q    <= vbep_pkg::NORMAL_RESET;
			ref_x_q <= '0;
			ref_y_q <= '0;
			ref_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vbep_pkg::REG_UP:     up_q    <= cfg_data;
				vbep_pkg::REG_NORMAL: nm_q    <= cfg_data;
				vbep_pkg::REG_REF_X:  ref_x_q <= cfg_data[CW-1:0];
				vbep_pkg::REG_REF_Y:  ref_y_q <= cfg_data[CW-1:0];
				vbep_pkg::REG_REF_Z:  ref_z_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	assign up = vbep_pkg::dir_t'(up_q);
	assign nm = vbep_pkg::dir_t'(nm_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xa_q <= vbep_pkg::XA_RESET;
		end else begin
			xa_q.x <= cross_term(up.y, nm.z, up.z, nm.y);
			xa_q.y <= cross_term(up.z, nm.x, up.x, nm.z);
			xa_q.z <= cross_term(up.x, nm.y, up.y, nm.x);
		end
	end

	// a stage loads when it is empty or its content moves on
	always_comb begin
		load5    = !v_s5 || out_ready;
		load4    = !v_s4 || load5;
		load3    = !v_s3 || load4;
		load2    = !v_s2 || load3;
		load1    = !v_s1 || load2;
		in_ready = load1;
		en.s2    = load2;
		en.s3    = load3;
		en.s4    = load4;
		en.s5    = load5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (load1) v_s1 <= in_valid;
			if (load2) v_s2 <= v_s1;
			if (load3) v_s3 <= v_s2;
			if (load4) v_s4 <= v_s3;
			if (load5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			d_lo_s1.x <= DW'(lower_x) - DW'(ref_x_q);
			d_lo_s1.y <= DW'(lower_y) - DW'(ref_y_q);
			d_lo_s1.z <= DW'(lower_z) - DW'(ref_z_q);
			d_hi_s1.x <= DW'(upper_x) - DW'(ref_x_q);
			d_hi_s1.y <= DW'(upper_y) - DW'(ref_y_q);
			d_hi_s1.z <= DW'(upper_z) - DW'(ref_z_q);
		end
	end

	for (genvar k = 0; k < vbep_pkg::NUM_LANES; k++) begin : g_lane
		assign corner[k].x = ((k & 1) != 0) ? d_hi_s1.x : d_lo_s1.x;
		assign corner[k].y = ((k & 2) != 0) ? d_hi_s1.y : d_lo_s1.y;
		assign corner[k].z = ((k & 4) != 0) ? d_hi_s1.z : d_lo_s1.z;

		vbep_lane u_lane (
			.clk (clk),
			.en  (en),
			.d   (corner[k]),
			.xa  (xa_q),
			.up  (up),
			.nm  (nm),
			.p   (lane_p[k])
		);
	end

	vbep_merge u_merge (
		.clk (clk),
		.en  (en),
		.p   (lane_p),
		.lo  (lo),
		.hi  (hi)
	);

	assign out_valid   = v_s5;
	assign view_min_x  = lo.x;
	assign view_min_y  = lo.y;
	assign view_far_z  = lo.z;
	assign view_max_x  = hi.x;
	assign view_max_y  = hi.y;
	assign view_near_z = hi.z;

	assign in_xfer    = in_valid && in_ready;
	assign out_xfer   = out_valid && out_ready;
	assign v_cnt      = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign v_cnt_next = v_cnt + 3'(in_xfer) - 3'(out_xfer);
	assign extent_ok  = lo.x <= hi.x && lo.y <= hi.y && lo.z <= hi.z;

	`VBEP_ASSERT(a_accept_fills_s1, in_xfer |=> v_s1, "accepted box not held in stage 1")
	`VBEP_ASSERT(a_item_count, 1'b1 |=> v_cnt == $past(v_cnt_next), "box lost or duplicated")
	`VBEP_ASSERT_IMPL(a_extent_order, out_valid, extent_ok, "extent bounds out of order")

endmodule

// File: test/tb_view_box_extent_projector.sv
// Self-checking testbench for view_box_extent_projector: random and corner-case boxes
// under several view settings, checked against an in-bench extent predictor.
// Depends on vbep_pkg and the RTL of the block only.
module tb_view_box_extent_projector;
	import vbep_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [COORD_W-1:0] HALF_Q16 = 32'sh0000_8000;
	localparam logic signed [COORD_W-1:0] ODD_BITS = 32'sh5555_5555;
	localparam logic signed [COORD_W-1:0] EVEN_BITS = 32'shAAAA_AAAA;
	localparam logic signed [DIR_W-1:0] DIR_MAX = 16'sh7FFF;
	localparam logic signed [DIR_W-1:0] DIR_MIN = 16'sh8000;
	localparam logic signed [DIR_W-1:0] UNIT_Q14 = 16'sd16384;

	typedef struct packed {
		logic signed [COORD_W-1:0] lower_x;
		logic signed [COORD_W-1:0] lower_y;
		logic signed [COORD_W-1:0] lower_z;
		logic signed [COORD_W-1:0] upper_x;
		logic signed [COORD_W-1:0] upper_y;
		logic signed [COORD_W-1:0] upper_z;
	} box_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] near_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] far_z;
	} extent_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	box_t box_now = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COORD_W-1:0] view_min_x, view_min_y, view_near_z;
	logic signed [COORD_W-1:0] view_max_x, view_max_y, view_far_z;

	// predictor copy of the view registers
	dir_t up_dir = UP_RESET;
	dir_t normal_dir = NORMAL_RESET;
	logic signed [COORD_W-1:0] ref_x = '0;
	logic signed [COORD_W-1:0] ref_y = '0;
	logic signed [COORD_W-1:0] ref_z = '0;

	box_t box_queue[$];
	extent_t extent_queue[$];
	int sent_total = 0;
	int results_seen = 0;
	int mismatches = 0;
	int send_gap = 0;
	int take_stall = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	view_box_extent_projector u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.lower_x(box_now.lower_x),
		.lower_y(box_now.lower_y),
		.lower_z(box_now.lower_z),
		.upper_x(box_now.upper_x),
		.upper_y(box_now.upper_y),
		.upper_z(box_now.upper_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.view_min_x(view_min_x),
		.view_min_y(view_min_y),
		.view_near_z(view_near_z),
		.view_max_x(view_max_x),
		.view_max_y(view_max_y),
		.view_far_z(view_far_z)
	);

	// floor((v + 2^13) / 2^14)
	function automatic longint round_q14(input longint v);
		return (v + longint'(8192)) >>> FRAC_SHIFT;
	endfunction

	function automatic longint sat_q16(input longint v);
		if (v > longint'(COORD_MAX))
			return longint'(COORD_MAX);
		if (v < longint'(COORD_MIN))
			return longint'(COORD_MIN);
		return v;
	endfunction

	function automatic extent_t project_extent(input box_t b);
		longint up[3], nm[3], xa[3], rf[3], lo[3], hi[3];
		longint d[3], p[3], mn[3], mx[3];
		extent_t e;
		up[0] = longint'($signed(up_dir.x));
		up[1] = longint'($signed(up_dir.y));
		up[2] = longint'($signed(up_dir.z));
		nm[0] = longint'($signed(normal_dir.x));
		nm[1] = longint'($signed(normal_dir.y));
		nm[2] = longint'($signed(normal_dir.z));
		xa[0] = round_q14(up[1] * nm[2] - up[2] * nm[1]);
		xa[1] = round_q14(up[2] * nm[0] - up[0] * nm[2]);
		xa[2] = round_q14(up[0] * nm[1] - up[1] * nm[0]);
		rf[0] = longint'(ref_x);
		rf[1] = longint'(ref_y);
		rf[2] = longint'(ref_z);
		lo[0] = longint'(b.lower_x);
		lo[1] = longint'(b.lower_y);
		lo[2] = longint'(b.lower_z);
		hi[0] = longint'(b.upper_x);
		hi[1] = longint'(b.upper_y);
		hi[2] = longint'(b.upper_z);
		for (int k = 0; k < NUM_LANES; k++) begin
			d[0] = ((k & 1) != 0 ? hi[0] : lo[0]) - rf[0];
			d[1] = ((k & 2) != 0 ? hi[1] : lo[1]) - rf[1];
			d[2] = ((k & 4) != 0 ? hi[2] : lo[2]) - rf[2];
			p[0] = sat_q16(round_q14(d[0] * xa[0] + d[1] * xa[1] + d[2] * xa[2]));
			p[1] = sat_q16(round_q14(d[0] * up[0] + d[1] * up[1] + d[2] * up[2]));
			p[2] = sat_q16(round_q14(d[0] * nm[0] + d[1] * nm[1] + d[2] * nm[2]));
			for (int i = 0; i < 3; i++) begin
				if (k == 0 || p[i] < mn[i])
					mn[i] = p[i];
				if (k == 0 || p[i] > mx[i])
					mx[i] = p[i];
			end
		end
		e.min_x = COORD_W'(mn[0]);
		e.min_y = COORD_W'(mn[1]);
		e.near_z = COORD_W'(mx[2]);
		e.max_x = COORD_W'(mx[0]);
		e.max_y = COORD_W'(mx[1]);
		e.far_z = COORD_W'(mn[2]);
		return e;
	endfunction

	// mostly back to back, sometimes a short gap, rarely a long one
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3, 4: return COORD_W'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [DIR_W-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return DIR_MIN;
			1: return DIR_MAX;
			2: return '0;
			3, 4: return DIR_W'(int'($urandom_range(0, 32768)) - 16384);
			default: return DIR_W'($urandom);
		endcase
	endfunction

	function automatic dir_t rand_dir();
		dir_t v;
		logic signed [DIR_W-1:0] unit;
		v.x = rand_comp();
		v.y = rand_comp();
		v.z = rand_comp();
		if ($urandom_range(0, 3) == 0) begin
			// axis-aligned unit vector, either sign
			unit = $urandom_range(0, 1) ? UNIT_Q14 : -UNIT_Q14;
			v = '0;
			case ($urandom_range(0, 2))
				0: v.x = unit;
				1: v.y = unit;
				default: v.z = unit;
			endcase
		end
		return v;
	endfunction

	task automatic check_field(input string name, input logic signed [COORD_W-1:0] want,
			input logic signed [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// sender: predict each box at its transfer, then load the next one after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				extent_queue.push_back(project_extent(box_now));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (box_queue.size() != 0) begin
					box_now <= box_queue.pop_front();
					in_valid <= 1'b1;
					send_gap <= pick_pause();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each transfer with the oldest predicted extent
	always @(posedge clk or negedge arst_n) begin
		extent_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			take_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (extent_queue.size() == 0) begin
					$error("extent transfer with no box pending");
					mismatches++;
				end else begin
					want = extent_queue.pop_front();
					check_field("view_min_x", want.min_x, view_min_x);
					check_field("view_min_y", want.min_y, view_min_y);
					check_field("view_near_z", want.near_z, view_near_z);
					check_field("view_max_x", want.max_x, view_max_x);
					check_field("view_max_y", want.max_y, view_max_y);
					check_field("view_far_z", want.far_z, view_far_z);
				end
			end
			if (take_stall != 0) begin
				out_ready <= 1'b0;
				take_stall <= take_stall - 1;
			end else begin
				out_ready <= 1'b1;
				take_stall <= pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_box(input logic signed [COORD_W-1:0] lx, ly, lz, ux, uy, uz);
		box_queue.push_back('{lower_x: lx, lower_y: ly, lower_z: lz,
			upper_x: ux, upper_y: uy, upper_z: uz});
		sent_total++;
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_box(rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic wait_drained();
		while (results_seen != sent_total)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_UP: up_dir = data;
			REG_NORMAL: normal_dir = data;
			REG_REF_X: ref_x = data[COORD_W-1:0];
			REG_REF_Y: ref_y = data[COORD_W-1:0];
			REG_REF_Z: ref_z = data[COORD_W-1:0];
			default: ;
		endcase
	endtask

	// junk in the bits above the reference registers, plus one write to an unused index
	task automatic apply_view(input dir_t up, input dir_t nm,
			input logic signed [COORD_W-1:0] rx, ry, rz);
		write_reg(REG_UP, up);
		write_reg(REG_NORMAL, nm);
		write_reg(REG_REF_X, {(CFG_W - COORD_W)'($urandom), rx});
		write_reg(REG_REF_Y, {(CFG_W - COORD_W)'($urandom), ry});
		write_reg(REG_REF_Z, {(CFG_W - COORD_W)'($urandom), rz});
		write_reg(REG_REF_Z + CFG_IDX_W'($urandom_range(1, 3)), CFG_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: up along x, normal along y
		send_box('0, '0, '0, '0, '0, '0);
		send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
		send_box(ONE_Q16, -2 * ONE_Q16, 3 * ONE_Q16, -ONE_Q16, 2 * ONE_Q16, -3 * ONE_Q16);
		send_box(32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1);
		send_box(EVEN_BITS, EVEN_BITS, EVEN_BITS, ODD_BITS, ODD_BITS, ODD_BITS);
		send_box(ODD_BITS, ODD_BITS, ODD_BITS, EVEN_BITS, EVEN_BITS, EVEN_BITS);
		send_box(COORD_MAX, '0, '0, '0, '0, '0);
		send_box('0, COORD_MIN, '0, '0, '0, COORD_MAX);
		send_box(HALF_Q16, -HALF_Q16, HALF_Q16, -HALF_Q16, HALF_Q16, ONE_Q16);
		send_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
		send_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
		send_random(60);
		wait_drained();

		// largest magnitudes, no idling
		steady = 1'b1;
		apply_view({DIR_MIN, DIR_MIN, DIR_MIN}, {DIR_MAX, DIR_MAX, DIR_MAX},
			COORD_MAX, COORD_MIN, '0);
		send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
		send_random(40);
		wait_drained();

		steady = 1'b0;
		apply_view({DIR_MAX, DIR_MIN, DIR_MAX}, {DIR_MIN, DIR_MAX, DIR_MIN},
			COORD_MIN, COORD_MAX, COORD_MIN);
		send_random(40);
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			steady = ($urandom_range(0, 3) == 0);
			apply_view(rand_dir(), rand_dir(), rand_coord(), rand_coord(), rand_coord());
			send_random(50);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (extent_queue.size() != 0) begin
			$error("%0d extents never arrived", extent_queue.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
